// ===== sv/color_ramp_keypoint_interpolator_top_macros.svh =====
// Assertion macros shared by the color ramp keypoint interpolator RTL.
`ifndef COLOR_RAMP_KEYPOINT_INTERPOLATOR_TOP_MACROS_SVH
`define COLOR_RAMP_KEYPOINT_INTERPOLATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define CRKI_ASSERT_SAME(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("Same-cycle implication failed.");
`define CRKI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("Next-cycle implication failed.");
`else
`define CRKI_ASSERT_SAME(label, clk, rstn, ante, cons)
`define CRKI_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== sv/crki_pkg.sv =====
// Types, constants and helpers of the color ramp keypoint interpolator.
package crki_pkg;

  localparam int INDEX_W = 7;
  localparam int COLOR_W = 8;
  localparam int RGB_W   = 24;
  localparam int WORD_W  = RGB_W + 1;

  localparam logic [RGB_W-1:0] WHITE_RGB = 24'hFFFFFF;

  typedef enum logic [1:0] {
    OP_READ      = 2'd0,
    OP_SET_COLOR = 2'd1,
    OP_SET_AUTO  = 2'd2,
    OP_RESET     = 2'd3
  } opcode_e;

  function automatic logic [COLOR_W-1:0] chan_of(input logic [RGB_W-1:0] rgb,
                                                 input logic [1:0] ch);
    logic [COLOR_W-1:0] v;
    case (ch)
      2'd0: v = rgb[23:16];
      2'd1: v = rgb[15:8];
      default: v = rgb[7:0];
    endcase
    return v;
  endfunction

endpackage

// ===== sv/color_ramp_keypoint_interpolator_top.sv =====
// Top level of the color ramp keypoint interpolator: sequencer, divider and table RAM.
//
//   Channel  Signals                                           Direction
//   input    in_valid_i, in_stall_o, opcode_i, entry_index_i,  into block
//            red_i, green_i, blue_i, auto_flag_i
//   output   out_valid_o, out_stall_i, accepted_o, read_red_o, out of block
//            read_green_o, read_blue_o, read_auto_o
//
// A read, an auto flag write or a refused color write passes the check state, then waits for the output transfer.
// A table reset sweeps the RAM, writing every entry to white with its auto flag set, before the output transfer.
// A color write adds a scan of the table, a division for each of the three channels of each segment to refill
// and one RAM write for each refilled entry.
// After reset a clearing pass over every entry runs before the first input transfer.
// One item is in work at a time; the result is held until its output transfer.
`include "color_ramp_keypoint_interpolator_top_macros.svh"

module color_ramp_keypoint_interpolator_top #(
  parameter int ENTRIES       = 128,
  parameter int FRACTION_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  crki_pkg::opcode_e opcode_i,
  input  logic [6:0]        entry_index_i,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  input  logic              auto_flag_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              accepted_o,
  output logic [7:0]        read_red_o,
  output logic [7:0]        read_green_o,
  output logic [7:0]        read_blue_o,
  output logic              read_auto_o
);

  import crki_pkg::*;

  localparam int AW  = $clog2(ENTRIES);
  localparam int XW  = (AW > INDEX_W) ? AW : INDEX_W;
  localparam int NW  = COLOR_W + FRACTION_BITS;
  localparam int SW  = NW + 1;
  localparam int ACW = NW + 2;
  localparam int RW  = AW + 1;
  localparam int CW  = $clog2(NW + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_TEST,
    S_DIV,
    S_FILL,
    S_OUT
  } state_e;

  state_e                state_q;
  opcode_e               op_q;
  logic [AW-1:0]         addr_q;
  logic                  idx_ok_q;
  logic [RGB_W-1:0]      rgb_q;
  logic                  flag_q;
  logic                  pend_q;
  logic [AW-1:0]         i_q;
  logic [AW-1:0]         prev_q;
  logic [AW-1:0]         j_q;
  logic                  have_prev_q;
  logic [RGB_W-1:0]      prev_rgb_q;
  logic [RGB_W-1:0]      key_rgb_q;
  logic [AW-1:0]         d_q;
  logic [1:0]            ch_q;
  logic [CW-1:0]         cnt_q;
  logic [NW-1:0]         num_q;
  logic [RW-1:0]         rem_q;
  logic                  neg_q;
  logic signed [SW-1:0]  step_q [3];
  logic signed [ACW-1:0] acc_q [3];
  logic                  res_acc_q;
  logic [WORD_W-1:0]     res_word_q;

  logic [XW-1:0]         in_idx_x;
  logic [AW-1:0]         in_addr;
  logic                  in_ok;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [WORD_W-1:0]     ram_rdata;
  logic [RW-1:0]         gap;
  logic [RW-1:0]         rem_sh;
  logic                  rem_ge;
  logic [RW-1:0]         rem_n;
  logic [NW-1:0]         num_n;
  logic [1:0]            ld_ch;
  logic [RGB_W-1:0]      ld_e_rgb;
  logic [COLOR_W-1:0]    ld_s;
  logic [COLOR_W-1:0]    ld_e;
  logic                  ld_neg;
  logic [COLOR_W-1:0]    ld_mag;
  logic [NW-1:0]         ld_num;
  logic signed [ACW-1:0] acc_next [3];
  logic [RGB_W-1:0]      fill_rgb;

  assign in_idx_x = XW'(entry_index_i);
  assign in_addr  = in_idx_x[AW-1:0];
  assign in_ok    = {1'b0, in_idx_x} < (XW + 1)'(ENTRIES);

  assign gap = {1'b0, i_q} - {1'b0, prev_q};

  assign rem_sh = {rem_q[RW-2:0], num_q[NW-1]};
  assign rem_ge = rem_sh >= {1'b0, d_q};
  assign rem_n  = rem_ge ? (rem_sh - {1'b0, d_q}) : rem_sh;
  assign num_n  = {num_q[NW-2:0], rem_ge};

  always_comb begin
    if (state_q == S_TEST) begin
      ld_ch    = 2'd0;
      ld_e_rgb = ram_rdata[RGB_W-1:0];
    end else begin
      ld_ch    = ch_q + 2'd1;
      ld_e_rgb = key_rgb_q;
    end
    ld_s   = chan_of(prev_rgb_q, ld_ch);
    ld_e   = chan_of(ld_e_rgb, ld_ch);
    ld_neg = ld_e < ld_s;
    ld_mag = ld_neg ? (ld_s - ld_e) : (ld_e - ld_s);
    ld_num = {ld_mag, {FRACTION_BITS{1'b0}}};
  end

  always_comb begin
    logic [ACW-1:0] rnd;
    for (int c = 0; c < 3; c++) begin
      acc_next[c] = acc_q[c] + ACW'(step_q[c]);
    end
    for (int c = 0; c < 3; c++) begin
      rnd = acc_next[c] + (ACW'(1) << (FRACTION_BITS - 1));
      fill_rgb[(2 - c) * COLOR_W +: COLOR_W] = rnd[FRACTION_BITS +: COLOR_W];
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = i_q;
    ram_wdata = {1'b1, WHITE_RGB};
    ram_raddr = i_q;
    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        ram_raddr = in_addr;
      end
      S_CHECK: begin
        ram_waddr = addr_q;
        if (idx_ok_q && op_q == OP_SET_COLOR && ram_rdata[RGB_W-1:0] != rgb_q) begin
          ram_we    = 1'b1;
          ram_wdata = {1'b0, rgb_q};
        end else if (idx_ok_q && op_q == OP_SET_AUTO) begin
          ram_we    = 1'b1;
          ram_wdata = {flag_q, ram_rdata[RGB_W-1:0]};
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = {1'b1, fill_rgb};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  crki_ram #(
    .WIDTH(WORD_W),
    .DEPTH(ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      op_q        <= OP_READ;
      addr_q      <= '0;
      idx_ok_q    <= 1'b0;
      rgb_q       <= '0;
      flag_q      <= 1'b0;
      pend_q      <= 1'b0;
      i_q         <= '0;
      prev_q      <= '0;
      j_q         <= '0;
      have_prev_q <= 1'b0;
      prev_rgb_q  <= '0;
      key_rgb_q   <= '0;
      d_q         <= '0;
      ch_q        <= '0;
      cnt_q       <= '0;
      num_q       <= '0;
      rem_q       <= '0;
      neg_q       <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        step_q[c] <= '0;
        acc_q[c]  <= '0;
      end
      res_acc_q   <= 1'b0;
      res_word_q  <= '0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          if (i_q == AW'(ENTRIES - 1)) begin
            state_q <= pend_q ? S_OUT : S_IDLE;
            pend_q  <= 1'b0;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            op_q     <= opcode_i;
            addr_q   <= in_addr;
            idx_ok_q <= in_ok;
            rgb_q    <= {red_i, green_i, blue_i};
            flag_q   <= auto_flag_i;
            if (opcode_i == OP_RESET) begin
              res_acc_q  <= in_ok;
              res_word_q <= in_ok ? {1'b1, WHITE_RGB} : '0;
              i_q        <= '0;
              pend_q     <= 1'b1;
              state_q    <= S_CLEAR;
            end else begin
              state_q <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (!idx_ok_q) begin
            res_acc_q  <= 1'b0;
            res_word_q <= '0;
            state_q    <= S_OUT;
          end else begin
            case (op_q)
              OP_SET_COLOR: begin
                if (ram_rdata[RGB_W-1:0] == rgb_q) begin
                  res_acc_q  <= 1'b0;
                  res_word_q <= ram_rdata;
                  state_q    <= S_OUT;
                end else begin
                  res_acc_q   <= 1'b1;
                  res_word_q  <= {1'b0, rgb_q};
                  i_q         <= '0;
                  have_prev_q <= 1'b0;
                  state_q     <= S_SCAN;
                end
              end
              OP_SET_AUTO: begin
                res_acc_q  <= 1'b1;
                res_word_q <= {flag_q, ram_rdata[RGB_W-1:0]};
                state_q    <= S_OUT;
              end
              default: begin
                res_acc_q  <= 1'b0;
                res_word_q <= ram_rdata;
                state_q    <= S_OUT;
              end
            endcase
          end
        end
        S_SCAN: begin
          state_q <= S_TEST;
        end
        S_TEST: begin
          if (!ram_rdata[RGB_W] && have_prev_q && gap >= RW'(2)) begin
            key_rgb_q <= ram_rdata[RGB_W-1:0];
            d_q       <= gap[AW-1:0];
            ch_q      <= 2'd0;
            cnt_q     <= '0;
            num_q     <= ld_num;
            rem_q     <= '0;
            neg_q     <= ld_neg;
            state_q   <= S_DIV;
          end else begin
            if (!ram_rdata[RGB_W]) begin
              prev_q      <= i_q;
              prev_rgb_q  <= ram_rdata[RGB_W-1:0];
              have_prev_q <= 1'b1;
            end
            if (i_q == AW'(ENTRIES - 1)) begin
              state_q <= S_OUT;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_SCAN;
            end
          end
        end
        S_DIV: begin
          if (cnt_q == CW'(NW - 1)) begin
            step_q[ch_q] <= neg_q ? -SW'(num_n) : SW'(num_n);
            cnt_q        <= '0;
            if (ch_q == 2'd2) begin
              for (int c = 0; c < 3; c++) begin
                acc_q[c] <= ACW'({chan_of(prev_rgb_q, 2'(c)), {FRACTION_BITS{1'b0}}});
              end
              j_q     <= prev_q + 1'b1;
              state_q <= S_FILL;
            end else begin
              ch_q  <= ld_ch;
              num_q <= ld_num;
              rem_q <= '0;
              neg_q <= ld_neg;
            end
          end else begin
            num_q <= num_n;
            rem_q <= rem_n;
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_FILL: begin
          for (int c = 0; c < 3; c++) begin
            acc_q[c] <= acc_next[c];
          end
          if (j_q == i_q - 1'b1) begin
            prev_q     <= i_q;
            prev_rgb_q <= key_rgb_q;
            if (i_q == AW'(ENTRIES - 1)) begin
              state_q <= S_OUT;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_SCAN;
            end
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        S_OUT: begin
          if (!out_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = (state_q == S_OUT);
  assign accepted_o   = res_acc_q;
  assign read_red_o   = res_word_q[23:16];
  assign read_green_o = res_word_q[15:8];
  assign read_blue_o  = res_word_q[7:0];
  assign read_auto_o  = res_word_q[RGB_W];

  `CRKI_ASSERT_SAME(a_no_input_while_result, clk_i, rst_ni, out_valid_o, in_stall_o)
  `CRKI_ASSERT_SAME(a_no_write_when_quiet, clk_i, rst_ni,
                    state_q == S_IDLE || state_q == S_OUT, !ram_we)
  `CRKI_ASSERT_SAME(a_fill_inside_segment, clk_i, rst_ni,
                    state_q == S_FILL, j_q > prev_q && j_q < i_q)
  `CRKI_ASSERT_SAME(a_read_not_accepted, clk_i, rst_ni,
                    out_valid_o && op_q == OP_READ, !accepted_o)
  `CRKI_ASSERT_NEXT(a_divide_then_fill, clk_i, rst_ni,
                    state_q == S_DIV && ch_q == 2'd2 && cnt_q == CW'(NW - 1),
                    state_q == S_FILL)

endmodule

// ===== sv/crki_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module crki_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the color ramp keypoint interpolator: directed and random traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import crki_pkg::*;

  localparam int          ENTRIES      = 128;
  localparam int          FRAC_BITS    = 16;
  localparam int          KEYPOINT_CAP = 12;
  localparam int          DRAIN_CYCLES = 50;
  localparam longint      CYCLE_LIMIT  = 25_000_000;

  typedef struct packed {
    logic       accepted;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       auto_bit;
  } ramp_result_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_stall_o;
  opcode_e    opcode_i      = OP_READ;
  logic [6:0] entry_index_i = '0;
  logic [7:0] red_i         = '0;
  logic [7:0] green_i       = '0;
  logic [7:0] blue_i        = '0;
  logic       auto_flag_i   = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i   = 1'b0;
  logic       accepted_o;
  logic [7:0] read_red_o;
  logic [7:0] read_green_o;
  logic [7:0] read_blue_o;
  logic       read_auto_o;

  logic [23:0]  ramp_rgb [ENTRIES];
  bit           ramp_auto [ENTRIES];
  ramp_result_t pending_results [$];

  int unsigned mismatches      = 0;
  int unsigned items_sent      = 0;
  int unsigned results_seen    = 0;
  int unsigned writes_taken    = 0;
  int unsigned writes_refused  = 0;
  int unsigned flag_writes     = 0;
  int unsigned table_clears    = 0;
  int unsigned calm_items      = 0;
  int unsigned stall_left      = 0;
  int unsigned stall_calm_left = 0;
  longint      cycles          = 0;
  bit          quiet           = 1'b0;

  color_ramp_keypoint_interpolator_top #(
    .ENTRIES      (ENTRIES),
    .FRACTION_BITS(FRAC_BITS)
  ) dut (.*);

  always #4 clk_i = ~clk_i;

  function automatic logic [7:0] lerp_channel(input logic [7:0] s, input logic [7:0] e,
                                              input int d, input int k);
    longint one;
    longint step;
    longint acc;
    longint v;
    one  = longint'(1) << FRAC_BITS;
    step = ((longint'(e) - longint'(s)) * one) / d;
    acc  = longint'(s) * one + step * k;
    if (acc < 0) acc = 0;
    v = (acc + (one >> 1)) / one;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic void clear_ramp();
    for (int i = 0; i < ENTRIES; i++) begin
      ramp_rgb[i]  = WHITE_RGB;
      ramp_auto[i] = 1'b1;
    end
  endfunction

  function automatic void refill_ramp();
    int prev;
    bit have_prev;
    prev      = 0;
    have_prev = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!ramp_auto[i]) begin
        if (have_prev && i - prev >= 2) begin
          for (int j = prev + 1; j < i; j++) begin
            for (int c = 0; c < 3; c++) begin
              ramp_rgb[j][8*c +: 8] = lerp_channel(ramp_rgb[prev][8*c +: 8],
                                                   ramp_rgb[i][8*c +: 8], i - prev, j - prev);
            end
          end
        end
        prev      = i;
        have_prev = 1'b1;
      end
    end
  endfunction

  function automatic int count_keypoints();
    int n;
    n = 0;
    for (int i = 0; i < ENTRIES; i++) if (!ramp_auto[i]) n++;
    return n;
  endfunction

  function automatic ramp_result_t predict_result(input opcode_e op, input logic [6:0] idx,
                                                  input logic [23:0] rgb, input logic flag);
    ramp_result_t res;
    res.accepted = 1'b0;
    case (op)
      OP_RESET: begin
        clear_ramp();
        res.accepted = 1'b1;
        table_clears++;
      end
      OP_SET_COLOR: begin
        if (ramp_rgb[idx] != rgb) begin
          ramp_rgb[idx]  = rgb;
          ramp_auto[idx] = 1'b0;
          refill_ramp();
          res.accepted = 1'b1;
          writes_taken++;
        end else begin
          writes_refused++;
        end
      end
      OP_SET_AUTO: begin
        ramp_auto[idx] = flag;
        res.accepted   = 1'b1;
        flag_writes++;
      end
      default: begin
      end
    endcase
    res.red      = ramp_rgb[idx][23:16];
    res.green    = ramp_rgb[idx][15:8];
    res.blue     = ramp_rgb[idx][7:0];
    res.auto_bit = ramp_auto[idx];
    return res;
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
             results_seen, field, got, want);
  endtask

  task automatic send_item(input opcode_e op, input logic [6:0] idx, input logic [23:0] rgb,
                           input logic flag);
    int unsigned  gap;
    ramp_result_t expected;
    gap = 0;
    if (!quiet) begin
      if (calm_items != 0) calm_items--;
      else if ($urandom_range(0, 24) == 0) calm_items = $urandom_range(5, 40);
      else if ($urandom_range(0, 3) == 0) gap = $urandom_range(1, 14);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    entry_index_i <= idx;
    red_i         <= rgb[23:16];
    green_i       <= rgb[15:8];
    blue_i        <= rgb[7:0];
    auto_flag_i   <= flag;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected = predict_result(op, idx, rgb, flag);
    pending_results.insert(pending_results.size(), expected);
    items_sent++;
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_after_reset();
    send_item(OP_READ, 7'd0, 24'($urandom), 1'b1);
    send_item(OP_READ, 7'd127, 24'($urandom), 1'b0);
    send_item(OP_SET_COLOR, 7'd64, 24'hFFFFFF, 1'b0);
  endtask

  task automatic test_gradient_fill();
    send_item(OP_SET_COLOR, 7'd3, 24'h000000, 1'b1);
    send_item(OP_SET_COLOR, 7'd100, 24'hFFAA55, 1'b0);
    send_item(OP_READ, 7'd50, 24'($urandom), 1'b0);
    send_item(OP_SET_COLOR, 7'd51, 24'hFF0000, 1'b1);
    send_item(OP_READ, 7'd50, 24'($urandom), 1'b1);
    send_item(OP_READ, 7'd52, 24'($urandom), 1'b0);
    send_item(OP_SET_COLOR, 7'd52, 24'h123456, 1'b0);
    send_item(OP_READ, 7'd99, 24'($urandom), 1'b1);
  endtask

  task automatic test_flag_and_reject();
    send_item(OP_SET_AUTO, 7'd51, 24'($urandom), 1'b1);
    send_item(OP_READ, 7'd51, 24'($urandom), 1'b0);
    send_item(OP_SET_COLOR, 7'd3, 24'h000000, 1'b1);
    send_item(OP_SET_AUTO, 7'd60, 24'($urandom), 1'b0);
    send_item(OP_SET_COLOR, 7'd100, 24'h00FF00, 1'b1);
    send_item(OP_READ, 7'd80, 24'($urandom), 1'b0);
    send_item(OP_READ, 7'd127, 24'($urandom), 1'b1);
    send_item(OP_READ, 7'd0, 24'($urandom), 1'b0);
  endtask

  task automatic test_table_clear();
    send_item(OP_RESET, 7'd127, 24'($urandom), 1'b1);
    send_item(OP_READ, 7'd3, 24'($urandom), 1'b0);
    send_item(OP_RESET, 7'd0, 24'($urandom), 1'b0);
  endtask

  task automatic test_random_traffic(input int count);
    int unsigned pick;
    logic [6:0]  idx;
    logic [23:0] rgb;
    logic        flag;
    opcode_e     op;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      idx  = 7'($urandom_range(0, ENTRIES - 1));
      flag = 1'($urandom_range(0, 1));
      for (int c = 0; c < 3; c++) begin
        case ($urandom_range(0, 3))
          0:       rgb[8*c +: 8] = 8'h00;
          1:       rgb[8*c +: 8] = 8'hFF;
          default: rgb[8*c +: 8] = 8'($urandom_range(0, 255));
        endcase
      end
      if (pick < 3) op = OP_RESET;
      else if (pick < 35) op = OP_READ;
      else if (pick < 75) op = OP_SET_COLOR;
      else op = OP_SET_AUTO;
      // Keep the keypoint count bounded so that refills stay short.
      if (count_keypoints() >= KEYPOINT_CAP) begin
        if (op == OP_SET_AUTO) flag = 1'b1;
        if (op == OP_SET_COLOR) begin
          do idx = 7'($urandom_range(0, ENTRIES - 1)); while (ramp_auto[idx]);
        end
      end
      if (op == OP_SET_COLOR && pick < 45) rgb = ramp_rgb[idx];
      send_item(op, idx, rgb, flag);
    end
  endtask

  task automatic test_full_rate(input int count);
    quiet = 1'b1;
    test_random_traffic(count);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || quiet) begin
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (stall_calm_left != 0) begin
      stall_calm_left--;
      out_stall_i <= 1'b0;
    end else begin
      case ($urandom_range(0, 15))
        0: begin
          stall_left = $urandom_range(0, 13);
          out_stall_i <= 1'b1;
        end
        1: begin
          stall_calm_left = $urandom_range(20, 300);
          out_stall_i <= 1'b0;
        end
        default: out_stall_i <= 1'b0;
      endcase
    end
  end

  always @(posedge clk_i) begin : check_results
    ramp_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("transfer with nothing expected", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (accepted_o !== want.accepted)
          report_mismatch("accepted", 32'(accepted_o), 32'(want.accepted));
        if (read_red_o !== want.red)
          report_mismatch("read_red", 32'(read_red_o), 32'(want.red));
        if (read_green_o !== want.green)
          report_mismatch("read_green", 32'(read_green_o), 32'(want.green));
        if (read_blue_o !== want.blue)
          report_mismatch("read_blue", 32'(read_blue_o), 32'(want.blue));
        if (read_auto_o !== want.auto_bit)
          report_mismatch("read_auto", 32'(read_auto_o), 32'(want.auto_bit));
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycles, pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    clear_ramp();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_after_reset();
    test_gradient_fill();
    test_flag_and_reject();
    test_table_clear();
    test_random_traffic(1000);
    test_full_rate(150);
    wait_for_results();
    $display("Checked %0d results from %0d transfers in %0d cycles.",
             results_seen, items_sent, cycles);
    $display("Ramp refills: %0d, unchanged colors refused: %0d, flag writes: %0d, clears: %0d.",
             writes_taken, writes_refused, flag_writes, table_clears);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
